// File: sv/mfgb_pkg.sv
package mfgb_pkg;

  localparam int PANEL_WIDTH  = 128;
  localparam int PANEL_HEIGHT = 64;
  localparam int STORE_DEPTH  = 1024;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int FB_BYTES     = PANEL_WIDTH * ((PANEL_HEIGHT + 7) / 8);

  localparam int GLYPH_W = 16;
  localparam int COL_W   = $clog2(GLYPH_W + 1);
  localparam int COLI_W  = $clog2(GLYPH_W);

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [2:0] REQ_FILL   = 3'd0;
  localparam logic [2:0] REQ_PIXEL  = 3'd1;
  localparam logic [2:0] REQ_CURSOR = 3'd2;
  localparam logic [2:0] REQ_GLYPH  = 3'd3;
  localparam logic [2:0] REQ_READ   = 3'd4;

  localparam logic [1:0] REG_INVERT  = 2'd0;
  localparam logic [1:0] REG_FWIDTH  = 2'd1;
  localparam logic [1:0] REG_FHEIGHT = 2'd2;

  localparam logic [4:0] FWIDTH_RST  = 5'd7;
  localparam logic [6:0] FHEIGHT_RST = 7'd10;

  typedef struct packed {
    logic       invert;
    logic [4:0] font_width;
    logic [6:0] font_height;
  } cfg_t;

  typedef struct packed {
    logic latch;
    logic sweep;
    logic sweep_zero;
    logic draw;
    logic rd_issue;
    logic rsp_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       reject;
    logic       sweep_last;
    logic       draw_done;
    logic       out_free;
  } sts_t;

endpackage

// File: sv/mfgb_req_if.sv
interface mfgb_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [7:0]  x_pos;
  logic [7:0]  y_pos;
  logic        pixel_color;
  logic [15:0] glyph_bits;
  logic [5:0]  glyph_row;
  logic        last_row;
  logic [9:0]  byte_index;

  modport source (
    output valid, req_type, x_pos, y_pos, pixel_color, glyph_bits, glyph_row,
           last_row, byte_index,
    input  ready
  );
  modport sink (
    input  valid, req_type, x_pos, y_pos, pixel_color, glyph_bits, glyph_row,
           last_row, byte_index,
    output ready
  );
endinterface

// File: sv/mfgb_rsp_if.sv
interface mfgb_rsp_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [7:0] read_byte;
  logic [7:0] cursor_col;
  logic [7:0] cursor_row;

  modport source (
    output valid, status, read_byte, cursor_col, cursor_row,
    input  ready
  );
  modport sink (
    input  valid, status, read_byte, cursor_col, cursor_row,
    output ready
  );
endinterface

// File: sv/mfgb_regs.sv
module mfgb_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mfgb_pkg::PADDR_W-1:0]  paddr,
  input  logic [mfgb_pkg::PDATA_W-1:0]  pwdata,
  output logic [mfgb_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output mfgb_pkg::cfg_t                cfg
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.invert      <= 1'b0;
      cfg.font_width  <= mfgb_pkg::FWIDTH_RST;
      cfg.font_height <= mfgb_pkg::FHEIGHT_RST;
    end else if (wr) begin
      case (idx)
        mfgb_pkg::REG_INVERT:  cfg.invert      <= pwdata[0];
        mfgb_pkg::REG_FWIDTH:  cfg.font_width  <= pwdata[4:0];
        mfgb_pkg::REG_FHEIGHT: cfg.font_height <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      mfgb_pkg::REG_INVERT:  prdata[0]   = cfg.invert;
      mfgb_pkg::REG_FWIDTH:  prdata[4:0] = cfg.font_width;
      mfgb_pkg::REG_FHEIGHT: prdata[6:0] = cfg.font_height;
      default: ;
    endcase
  end

endmodule

// File: sv/mfgb_ctrl.sv
module mfgb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mfgb_pkg::sts_t sts,
  output mfgb_pkg::cmd_t cmd
);

  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_DISPATCH = 3'd2;
  localparam logic [2:0] ST_FILL     = 3'd3;
  localparam logic [2:0] ST_DRAW     = 3'd4;
  localparam logic [2:0] ST_READ     = 3'd5;
  localparam logic [2:0] ST_DONE     = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        cmd.sweep      = 1'b1;
        cmd.sweep_zero = 1'b1;
        if (sts.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts.req)
          mfgb_pkg::REQ_FILL:  state_next = ST_FILL;
          mfgb_pkg::REQ_PIXEL: state_next = sts.reject ? ST_DONE : ST_DRAW;
          mfgb_pkg::REQ_GLYPH: state_next = sts.reject ? ST_DONE : ST_DRAW;
          mfgb_pkg::REQ_READ:  state_next = sts.reject ? ST_DONE : ST_READ;
          default:             state_next = ST_DONE;
        endcase
      end
      ST_FILL: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) state_next = ST_DONE;
      end
      ST_DRAW: begin
        cmd.draw = 1'b1;
        if (sts.draw_done) state_next = ST_DONE;
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.rsp_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.rsp_load |-> sts.out_free)
    else $error("result loaded over a waiting result");

  a_draw_req: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAW |->
      !sts.reject && (sts.req == mfgb_pkg::REQ_PIXEL || sts.req == mfgb_pkg::REQ_GLYPH))
    else $error("draw for a rejected or non-drawing item");

  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep |-> !cmd.draw && !cmd.rd_issue)
    else $error("sweep clashes with draw or read on the store");

endmodule

// File: sv/mfgb_dp.sv
module mfgb_dp (
  input  logic           clk,
  input  logic           rst,
  input  mfgb_pkg::cfg_t cfg,
  input  mfgb_pkg::cmd_t cmd,
  output mfgb_pkg::sts_t sts,
  input  logic [2:0]     req_type,
  input  logic [7:0]     x_pos,
  input  logic [7:0]     y_pos,
  input  logic           pixel_color,
  input  logic [15:0]    glyph_bits,
  input  logic [5:0]     glyph_row,
  input  logic           last_row,
  input  logic [9:0]     byte_index,
  input  logic           out_ready,
  output logic           out_valid,
  output logic           status,
  output logic [7:0]     read_byte,
  output logic [7:0]     cursor_col,
  output logic [7:0]     cursor_row
);

  localparam int AW = mfgb_pkg::ADDR_W;
  localparam int CW = mfgb_pkg::COL_W;
  localparam int IW = mfgb_pkg::COLI_W;
  localparam int GW = mfgb_pkg::GLYPH_W;

  logic [7:0]    mem [mfgb_pkg::STORE_DEPTH];
  logic [7:0]    rd_data;

  logic [7:0]    text_col;
  logic [7:0]    text_row;

  logic [2:0]    req_l;
  logic          reject_l;
  logic [7:0]    base_x;
  logic [7:0]    y_l;
  logic [GW-1:0] bits_l;
  logic [CW-1:0] w_l;
  logic          color_l;
  logic [AW-1:0] byte_l;

  logic [AW-1:0] cnt;
  logic [CW-1:0] col;
  logic          pend;
  logic [IW-1:0] pend_col;

  logic [CW-1:0] w_eff;
  logic [7:0]    glyph_y;
  logic          pix_off;
  logic          glyph_rej;
  logic          read_oob;
  logic          reject_in;

  logic          issue;
  logic [AW-1:0] rd_addr_draw;
  logic [AW-1:0] wr_addr_draw;
  logic [GW-1:0] bits_sh;
  logic          px;
  logic [7:0]    bit_mask;
  logic [7:0]    draw_byte;

  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          re;
  logic [AW-1:0] raddr;

  function automatic logic [AW-1:0] addr_of(input logic [7:0] x, input logic [7:0] y);
    addr_of = AW'(x) + AW'(y >> 3) * AW'(mfgb_pkg::PANEL_WIDTH);
  endfunction

  // request checks on the incoming item
  always_comb begin
    w_eff     = (cfg.font_width > 5'(GW)) ? CW'(GW) : CW'(cfg.font_width);
    glyph_y   = text_row + {2'b00, glyph_row};
    pix_off   = ({1'b0, x_pos} >= 9'(mfgb_pkg::PANEL_WIDTH)) ||
                ({1'b0, y_pos} >= 9'(mfgb_pkg::PANEL_HEIGHT));
    glyph_rej = (({1'b0, text_col} + 9'(w_eff)) > 9'(mfgb_pkg::PANEL_WIDTH)) ||
                (({1'b0, text_row} + 9'(cfg.font_height)) > 9'(mfgb_pkg::PANEL_HEIGHT)) ||
                ({1'b0, glyph_row} >= cfg.font_height);
    read_oob  = ({1'b0, byte_index} >= 11'(mfgb_pkg::FB_BYTES));
    case (req_type)
      mfgb_pkg::REQ_FILL:   reject_in = 1'b0;
      mfgb_pkg::REQ_PIXEL:  reject_in = pix_off;
      mfgb_pkg::REQ_CURSOR: reject_in = 1'b0;
      mfgb_pkg::REQ_GLYPH:  reject_in = glyph_rej;
      mfgb_pkg::REQ_READ:   reject_in = read_oob;
      default:              reject_in = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_l    <= req_type;
      reject_l <= reject_in;
      color_l  <= pixel_color;
      byte_l   <= AW'(byte_index);
      if (req_type == mfgb_pkg::REQ_PIXEL) begin
        base_x <= x_pos;
        y_l    <= y_pos;
        bits_l <= GW'(1) << (GW - 1);
        w_l    <= CW'(1);
      end else begin
        base_x <= text_col;
        y_l    <= glyph_y;
        bits_l <= glyph_bits;
        w_l    <= w_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_col <= '0;
      text_row <= '0;
    end else if (cmd.latch) begin
      if (req_type == mfgb_pkg::REQ_CURSOR) begin
        text_col <= x_pos;
        text_row <= y_pos;
      end else if (req_type == mfgb_pkg::REQ_GLYPH && !glyph_rej && last_row) begin
        text_col <= text_col + 8'(w_eff);
      end
    end
  end

  // column walk: read one byte, write it back modified in the following cycle
  assign issue        = col < w_l;
  assign rd_addr_draw = addr_of(base_x + 8'(col), y_l);
  assign wr_addr_draw = addr_of(base_x + 8'(pend_col), y_l);
  assign bits_sh      = bits_l << pend_col;
  assign px           = (bits_sh[GW-1] ? color_l : !color_l) ^ cfg.invert;
  assign bit_mask     = 8'(1) << y_l[2:0];
  assign draw_byte    = px ? (rd_data | bit_mask) : (rd_data & ~bit_mask);

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      pend <= 1'b0;
      cnt  <= '0;
    end else begin
      if (cmd.latch) begin
        col  <= '0;
        pend <= 1'b0;
      end else if (cmd.draw) begin
        if (issue) col <= col + CW'(1);
        pend <= issue;
      end
      if (cmd.sweep) cnt <= cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.draw) pend_col <= col[IW-1:0];
  end

  always_comb begin
    we    = cmd.sweep | (cmd.draw & pend);
    waddr = cmd.sweep ? cnt : wr_addr_draw;
    wdata = cmd.sweep ? (cmd.sweep_zero ? 8'h00 : {8{color_l}}) : draw_byte;
    re    = cmd.rd_issue | (cmd.draw & issue);
    raddr = cmd.rd_issue ? byte_l : rd_addr_draw;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_data <= mem[raddr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.rsp_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rsp_load) begin
      status     <= reject_l;
      read_byte  <= (req_l == mfgb_pkg::REQ_READ && !reject_l) ? rd_data : 8'h00;
      cursor_col <= text_col;
      cursor_row <= text_row;
    end
  end

  always_comb begin
    sts.req        = req_l;
    sts.reject     = reject_l;
    sts.sweep_last = (cnt == AW'(mfgb_pkg::STORE_DEPTH - 1));
    sts.draw_done  = !issue && !pend;
    sts.out_free   = !out_valid || out_ready;
  end

  a_pend_col: assert property (@(posedge clk) disable iff (rst)
    pend |-> CW'(pend_col) < w_l)
    else $error("write-back column beyond glyph width");

  a_cursor_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.latch |=> $stable(text_col) && $stable(text_row))
    else $error("cursor moved without a new item");

endmodule

// File: sv/mono_framebuffer_glyph_blitter.sv
// Page-organised 1-bit framebuffer (128 x 64, 1024 bytes) with a text cursor.
// Items arrive on req (valid/ready); each gives exactly one result on rsp
// carrying status, read_byte and the cursor after the item.
// Config (invert, font width, font height) is written over the APB port at
// byte addresses 0, 4 and 8; the user must write it only while no item is in
// flight, and the block itself does not enforce this. A glyph row makes one
// store read per column, with the write-back overlapped with the next read;
// a fill writes one store byte per cycle.
// One item is in work at a time; a new item is taken while the previous
// result waits in the output register.
// Reset clears control and runs a clearing pass over all 1024 store bytes,
// during which ready stays low; config writes are taken as ever.
// If the receiver stalls, the result holds and a finished item waits for it.
module mono_framebuffer_glyph_blitter (
  input  logic                          clk,
  input  logic                          rst,
  mfgb_req_if.sink                      req,
  mfgb_rsp_if.source                    rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mfgb_pkg::PADDR_W-1:0]  paddr,
  input  logic [mfgb_pkg::PDATA_W-1:0]  pwdata,
  output logic [mfgb_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  mfgb_pkg::cfg_t cfg;
  mfgb_pkg::cmd_t cmd;
  mfgb_pkg::sts_t sts;

  mfgb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mfgb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mfgb_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .sts         (sts),
    .req_type    (req.req_type),
    .x_pos       (req.x_pos),
    .y_pos       (req.y_pos),
    .pixel_color (req.pixel_color),
    .glyph_bits  (req.glyph_bits),
    .glyph_row   (req.glyph_row),
    .last_row    (req.last_row),
    .byte_index  (req.byte_index),
    .out_ready   (rsp.ready),
    .out_valid   (rsp.valid),
    .status      (rsp.status),
    .read_byte   (rsp.read_byte),
    .cursor_col  (rsp.cursor_col),
    .cursor_row  (rsp.cursor_row)
  );

endmodule

// File: sim/mfgb_frame_checker.sv
`timescale 1ns / 1ps

module mfgb_frame_checker
  import mfgb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  mfgb_req_if                req,
  mfgb_rsp_if                rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  output int                 errors,
  output int                 in_flight,
  output int                 results_seen
);

  typedef struct packed {
    logic       status;
    logic [7:0] read_byte;
    logic [7:0] cursor_col;
    logic [7:0] cursor_row;
  } blit_result_t;

  logic [7:0]   frame [STORE_DEPTH];
  logic [7:0]   col_now;
  logic [7:0]   row_now;
  cfg_t         settings;
  blit_result_t due_results [$];
  blit_result_t want;

  task automatic report(input string what);
    $display("%0t result %0d: %s", $time, results_seen, what);
    errors++;
  endtask

  // returns 1 when the pixel lies on the panel and was written
  function automatic bit plot_pixel(input int x, input int y, input logic white);
    int         idx;
    logic [7:0] mask;
    if (x >= PANEL_WIDTH || y >= PANEL_HEIGHT) return 1'b0;
    idx  = x + (y / 8) * PANEL_WIDTH;
    mask = 8'h01 << (y % 8);
    if (white ^ settings.invert) frame[idx] |= mask;
    else frame[idx] &= ~mask;
    return 1'b1;
  endfunction

  function automatic blit_result_t render_item();
    blit_result_t r;
    int           w;
    r = '0;
    w = (settings.font_width > GLYPH_W) ? GLYPH_W : int'(settings.font_width);
    case (req.req_type)
      REQ_FILL: begin
        for (int i = 0; i < STORE_DEPTH; i++) frame[i] = {8{req.pixel_color}};
      end
      REQ_PIXEL: begin
        r.status = !plot_pixel(req.x_pos, req.y_pos, req.pixel_color);
      end
      REQ_CURSOR: begin
        col_now = req.x_pos;
        row_now = req.y_pos;
      end
      REQ_GLYPH: begin
        if (col_now + w > PANEL_WIDTH || row_now + settings.font_height > PANEL_HEIGHT ||
            req.glyph_row >= settings.font_height) begin
          r.status = 1'b1;
        end else begin
          for (int c = 0; c < w; c++)
            void'(plot_pixel(col_now + c, row_now + req.glyph_row,
                             req.glyph_bits[GLYPH_W-1-c] ? req.pixel_color
                                                         : !req.pixel_color));
          if (req.last_row) col_now = col_now + w[7:0];
        end
      end
      REQ_READ: begin
        if (req.byte_index < FB_BYTES) r.read_byte = frame[req.byte_index];
        else r.status = 1'b1;
      end
      default: r.status = 1'b1;
    endcase
    r.cursor_col = col_now;
    r.cursor_row = row_now;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STORE_DEPTH; i++) frame[i] = '0;
      col_now  = '0;
      row_now  = '0;
      settings = '{1'b0, FWIDTH_RST, FHEIGHT_RST};
      due_results.delete();
      errors = 0;
      in_flight    <= 0;
      results_seen <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_INVERT:  settings.invert      = pwdata[0];
          REG_FWIDTH:  settings.font_width  = pwdata[4:0];
          REG_FHEIGHT: settings.font_height = pwdata[6:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) due_results.push_back(render_item());
      if (rsp.valid && rsp.ready) begin
        if (due_results.size() == 0) begin
          report("result with no item outstanding");
        end else begin
          want = due_results.pop_front();
          if (rsp.status !== want.status)
            report($sformatf("status %0h, predicted %0h", rsp.status, want.status));
          if (rsp.read_byte !== want.read_byte)
            report($sformatf("read_byte %0h, predicted %0h", rsp.read_byte,
                             want.read_byte));
          if (rsp.cursor_col !== want.cursor_col)
            report($sformatf("cursor_col %0d, predicted %0d", rsp.cursor_col,
                             want.cursor_col));
          if (rsp.cursor_row !== want.cursor_row)
            report($sformatf("cursor_row %0d, predicted %0d", rsp.cursor_row,
                             want.cursor_row));
        end
        results_seen <= results_seen + 1;
      end
      in_flight <= due_results.size();
    end
  end

endmodule

// File: sim/mono_framebuffer_glyph_blitter_test.sv
`timescale 1ns / 1ps

module mono_framebuffer_glyph_blitter_test
  import mfgb_pkg::*;
;

  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 185;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 8000;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int errors;
  int in_flight;
  int results_seen;
  int items_sent;
  int quiet;
  int sender_mode;
  int receiver_mode;
  int hold_requests;

  mfgb_req_if req_ch ();
  mfgb_rsp_if rsp_ch ();

  mono_framebuffer_glyph_blitter u_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  mfgb_frame_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .errors       (errors),
    .in_flight    (in_flight),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // 0: never idle, 1: a random wait before every item, 2: mostly back to back
  function automatic int draw_wait(input int mode);
    case (mode)
      1: return $urandom_range(15);
      2: return ($urandom_range(3) == 0) ? $urandom_range(15) : 0;
      default: return 0;
    endcase
  endfunction

  task automatic issue(input logic [2:0] kind, input logic [7:0] x, input logic [7:0] y,
                       input logic color, input logic [15:0] bits, input logic [5:0] row,
                       input logic last, input logic [9:0] idx);
    int gap;
    gap = draw_wait(sender_mode);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= kind;
    req_ch.x_pos       <= x;
    req_ch.y_pos       <= y;
    req_ch.pixel_color <= color;
    req_ch.glyph_bits  <= bits;
    req_ch.glyph_row   <= row;
    req_ch.last_row    <= last;
    req_ch.byte_index  <= idx;
    do @(posedge clk); while (!req_ch.ready);
    if (kind <= REQ_READ) items_sent++;
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
  endtask

  // result side
  initial begin
    int stall;
    int holds_done;
    holds_done = 0;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_requests != holds_done) begin
        holds_done = hold_requests;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = draw_wait(receiver_mode);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (psel && penable && pready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("mono_framebuffer_glyph_blitter: mismatch");
        $finish;
      end
    end
  end

  initial begin
    cfg_t       setting;
    logic [1:0] reg_sel [3];
    logic [31:0] reg_val [3];
    int         w_eff;
    int         h;
    int         rows;
    int         pen_x;
    int         pen_y;
    int         pick;
    int         px;
    int         py;
    int         target;
    bit         held;
    bit         paused;
    bit         broken;
    logic       colour;

    reg_sel = '{REG_INVERT, REG_FWIDTH, REG_FHEIGHT};
    held = 1'b0;
    paused = 1'b0;
    pen_x = 0;
    pen_y = 0;
    items_sent = 0;
    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= REQ_FILL;
    req_ch.x_pos       <= '0;
    req_ch.y_pos       <= '0;
    req_ch.pixel_color <= 1'b0;
    req_ch.glyph_bits  <= '0;
    req_ch.glyph_row   <= '0;
    req_ch.last_row    <= 1'b0;
    req_ch.byte_index  <= '0;
    sender_mode        <= 2;
    receiver_mode      <= 1;
    hold_requests      <= 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, width 7, height 10
    issue(REQ_READ, 0, 0, 0, 0, 0, 0, 10'd0);
    issue(REQ_READ, 0, 0, 0, 0, 0, 0, 10'd1023);
    issue(REQ_FILL, 8'hFF, 8'hFF, 1'b1, 16'hFFFF, 6'h3F, 1'b1, 10'h3FF);
    issue(REQ_READ, 0, 0, 0, 0, 0, 0, 10'd517);
    issue(REQ_FILL, 0, 0, 1'b0, 0, 0, 0, 0);
    issue(REQ_PIXEL, 8'd0, 8'd0, 1'b1, 0, 0, 0, 0);
    issue(REQ_PIXEL, 8'd127, 8'd63, 1'b1, 0, 0, 0, 0);
    issue(REQ_PIXEL, 8'd128, 8'd0, 1'b1, 0, 0, 0, 0);
    issue(REQ_PIXEL, 8'd0, 8'd64, 1'b1, 0, 0, 0, 0);
    issue(REQ_PIXEL, 8'd255, 8'd255, 1'b1, 0, 0, 0, 0);
    issue(REQ_READ, 0, 0, 0, 0, 0, 0, 10'd0);
    issue(REQ_READ, 0, 0, 0, 0, 0, 0, 10'd1023);
    for (int u = REQ_READ + 1; u < 8; u++) issue(u[2:0], 8'd5, 8'd5, 1'b1, 16'hFFFF, 0, 1, 0);
    issue(REQ_CURSOR, 8'd121, 8'd54, 0, 0, 0, 0, 0);
    issue(REQ_GLYPH, 0, 0, 1'b1, 16'hFFFF, 6'd0, 1'b0, 0);
    issue(REQ_GLYPH, 0, 0, 1'b0, 16'h8001, 6'd9, 1'b1, 0);
    issue(REQ_GLYPH, 0, 0, 1'b1, 16'hA5A5, 6'd0, 1'b1, 0);
    issue(REQ_CURSOR, 8'd0, 8'd55, 0, 0, 0, 0, 0);
    issue(REQ_GLYPH, 0, 0, 1'b1, 16'hFFFF, 6'd0, 1'b1, 0);
    issue(REQ_CURSOR, 8'd0, 8'd0, 0, 0, 0, 0, 0);
    issue(REQ_GLYPH, 0, 0, 1'b1, 16'hFFFF, 6'd10, 1'b1, 0);
    issue(REQ_GLYPH, 0, 0, 1'b1, 16'hFFFF, 6'd63, 1'b1, 0);
    issue(REQ_READ, 0, 0, 0, 0, 0, 0, 10'd889);
    issue(REQ_READ, 0, 0, 0, 0, 0, 0, 10'd1017);

    for (int phase = 1; phase <= PHASES; phase++) begin
      drain();
      case (phase)
        1: setting = '{1'b1, 5'd16, 7'd64};
        2: setting = '{1'b0, 5'd1, 7'd1};
        3: setting = '{1'b1, 5'd0, 7'd0};
        4: setting = '{1'b0, 5'd31, 7'd127};
        5: setting = '{1'b0, 5'd8, 7'd8};
        6: setting = '{1'b1, 5'd5, 7'd7};
        7: setting = '{1'b0, 5'd12, 7'd16};
        default: begin
          setting.invert      = $urandom_range(1);
          setting.font_width  = $urandom_range(16, 1);
          setting.font_height = $urandom_range(64, 1);
        end
      endcase
      reg_val[0] = 32'(setting.invert);
      reg_val[1] = 32'(setting.font_width);
      reg_val[2] = 32'(setting.font_height);
      for (int k = 0; k < 3; k++) begin
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel[k], 2'b00};
        pwdata  <= reg_val[k];
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sender_mode   <= phase % 3;
      receiver_mode <= (phase + 1) % 3;

      w_eff  = (setting.font_width > GLYPH_W) ? GLYPH_W : int'(setting.font_width);
      h      = setting.font_height;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        // result side stalls long while items keep coming
        if (phase == 2 && !held && items_sent >= target - 120) begin
          hold_requests <= hold_requests + 1;
          held = 1'b1;
        end
        if (phase == 5 && !paused && items_sent >= target - 90) begin
          drain();
          paused = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 45) begin
          if ($urandom_range(3) != 0) begin
            if ($urandom_range(7) == 0) begin
              pen_x = $urandom_range(255);
              pen_y = $urandom_range(255);
            end else begin
              pen_x = $urandom_range(PANEL_WIDTH - w_eff);
              pen_y = (h <= PANEL_HEIGHT) ? $urandom_range(PANEL_HEIGHT - h)
                                          : $urandom_range(PANEL_HEIGHT - 1);
            end
            issue(REQ_CURSOR, pen_x, pen_y, $urandom, $urandom, $urandom, $urandom, $urandom);
          end
          rows   = (h > 64) ? 64 : ((h == 0) ? 1 : h);
          broken = ($urandom_range(9) == 0);
          colour = $urandom_range(1);
          for (int g = 0; g < rows; g++)
            issue(REQ_GLYPH, $urandom, $urandom, colour, $urandom,
                  broken ? 6'($urandom) : 6'(g), broken ? 1'($urandom) : (g == rows - 1),
                  $urandom);
          if (w_eff > 0 && h > 0 && pen_x + w_eff <= PANEL_WIDTH &&
              pen_y + h <= PANEL_HEIGHT) begin
            repeat (2)
              issue(REQ_READ, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    pen_x + $urandom_range(w_eff - 1) +
                    ((pen_y + $urandom_range(h - 1)) / 8) * PANEL_WIDTH);
            if (!broken) pen_x += w_eff;
          end
        end else if (pick < 60) begin
          if ($urandom_range(4) == 0) begin
            px = $urandom_range(255);
            py = $urandom_range(255);
          end else begin
            px = $urandom_range(PANEL_WIDTH - 1);
            py = $urandom_range(PANEL_HEIGHT - 1);
          end
          issue(REQ_PIXEL, px, py, $urandom, $urandom, $urandom, $urandom, $urandom);
          if (px < PANEL_WIDTH && py < PANEL_HEIGHT && $urandom_range(1) == 1)
            issue(REQ_READ, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  px + (py / 8) * PANEL_WIDTH);
        end else if (pick < 85) begin
          issue(REQ_READ, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom);
        end else if (pick < 99) begin
          issue($urandom_range(7, REQ_PIXEL), $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom);
        end else begin
          issue(REQ_FILL, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom);
        end
      end
    end

    drain();
    repeat (64) @(posedge clk);
    $display("covered %0d items, %0d results checked, %0d register settings", items_sent,
             results_seen, PHASES + 1);
    $display("incl. fills, off-panel pixels, edge-crossing glyphs, zero and wide fonts");
    if (errors == 0) begin
      $display("mono_framebuffer_glyph_blitter: match");
    end else begin
      $display("mono_framebuffer_glyph_blitter: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/mfgb_pkg.sv
sv/mfgb_req_if.sv
sv/mfgb_rsp_if.sv
sv/mfgb_regs.sv
sv/mfgb_ctrl.sv
sv/mfgb_dp.sv
sv/mono_framebuffer_glyph_blitter.sv
sim/mfgb_frame_checker.sv
sim/mono_framebuffer_glyph_blitter_test.sv
